// ----- sv/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  // Derived widths
  localparam int AW  = $clog2(CELLS);             // cell address
  localparam int PW  = $clog2(CELLS + 1);         // cursor, includes past-the-end
  localparam int RW  = $clog2(ROWS + 1);          // cursor row, includes past-the-end
  localparam int CLW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Port field widths
  localparam int FUNC_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;
  localparam int CFG_IW   = 1;
  localparam int CFG_DW   = 8;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'h0A;
  localparam logic [CHAR_W-1:0] ERROR_CHAR     = 8'h45;
  localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'd7;
  localparam logic [ATTR_W-1:0] ERROR_ATTR_RST = 8'd207;

  // Command queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Request function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT_CHAR   = 3'd0,
    FUNC_NEWLINE    = 3'd1,
    FUNC_BACKSPACE  = 3'd2,
    FUNC_CLEAR      = 3'd3,
    FUNC_READ_CELL  = 3'd4,
    FUNC_ERROR_MARK = 3'd5
  } func_e;

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_TEXT_ATTR  = 1'b0,
    CFG_ERROR_ATTR = 1'b1
  } cfg_reg_e;

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_PUT_LF,
    CMD_LF,
    CMD_BS,
    CMD_CLEAR,
    CMD_READ,
    CMD_ERROR,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [CHAR_W-1:0]  ch;
    logic [AW-1:0]      idx;
    logic               in_range;
  } cmd_t;

  // Executor states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_BLANK,
    ST_APPLY,
    ST_READ,
    ST_FILL
  } back_state_e;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

// ----- sv/text_console_writer_unit.sv -----
`timescale 1ns / 1ps
// Backspace, error mark, unused codes and newline without scroll give their result
//   straight from the idle state; put char passes the apply state, read cell the read
//   state. A scroll (shift, then blank of the last row) and a clear (fill) rewrite the
//   whole store through its one write port. The next request leaves the queue only in idle.
// Reset: cursor 0, attributes 7 and 207; a clearing pass blanks the screen store,
//   and no request is taken until it ends.
module text_console_writer_unit import tcw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FUNC_W-1:0]    func_i,
  input  logic [CHAR_W-1:0]    char_code_i,
  input  logic [INDEX_W-1:0]   cell_index_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CURSOR_W-1:0]  cursor_cell_o,
  output logic [CHAR_W-1:0]    read_char_o,
  output logic [ATTR_W-1:0]    read_attr_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IW-1:0]    cfg_index_i,
  input  logic [CFG_DW-1:0]    cfg_wdata_i
);

  logic [ATTR_W-1:0] text_attr_q, text_attr_d;
  logic [ATTR_W-1:0] error_attr_q, error_attr_d;
  back_status_t      status;
  cmd_t              push_cmd;
  cmd_t              head_cmd;
  logic              push;
  logic              pop;
  logic              fifo_full;
  logic              fifo_empty;

  // Configuration registers
  always_comb begin
    text_attr_d  = text_attr_q;
    error_attr_d = error_attr_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TEXT_ATTR:  text_attr_d  = cfg_wdata_i;
        CFG_ERROR_ATTR: error_attr_d = cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q  <= TEXT_ATTR_RST;
      error_attr_q <= ERROR_ATTR_RST;
    end else begin
      text_attr_q  <= text_attr_d;
      error_attr_q <= error_attr_d;
    end
  end

  tcw_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .status_i     (status),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  tcw_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  tcw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_attr_i   (text_attr_q),
    .error_attr_i  (error_attr_q),
    .head_i        (head_cmd),
    .empty_i       (fifo_empty),
    .pop_o         (pop),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cursor_cell_o (cursor_cell_o),
    .read_char_o   (read_char_o),
    .read_attr_o   (read_attr_o)
  );

  // Cursor never beyond the past-the-end cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(cursor_cell_o) <= CELLS))
    else $error("cursor beyond screen");

  // No request enters during the reset clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.init_busy |-> !push)
    else $error("request taken during clearing pass");

  // The reset pass itself produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(status.init_busy) |-> !out_valid_o)
    else $error("result from reset pass");

  // Queue never popped when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_empty)
    else $error("pop from empty queue");

endmodule

// ----- sv/tcw_front.sv -----
`timescale 1ns / 1ps

module tcw_front import tcw_pkg::*; (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [INDEX_W-1:0]  cell_index_i,
  input  back_status_t        status_i,
  input  logic                fifo_full_i,
  output logic                push_o,
  output cmd_t                cmd_o
);

  // Hold off while the queue is full or the reset pass runs
  assign in_stall_o = fifo_full_i | status_i.init_busy;
  assign push_o     = in_valid_i & ~in_stall_o;

  // Classify the request
  always_comb begin
    cmd_o.ch       = char_code_i;
    cmd_o.idx      = AW'(cell_index_i);
    cmd_o.in_range = (32'(cell_index_i) < CELLS);
    unique case (func_i)
      FUNC_PUT_CHAR: begin
        cmd_o.kind = (char_code_i == NEWLINE_CHAR) ? CMD_PUT_LF : CMD_PUT;
      end
      FUNC_NEWLINE:    cmd_o.kind = CMD_LF;
      FUNC_BACKSPACE:  cmd_o.kind = CMD_BS;
      FUNC_CLEAR:      cmd_o.kind = CMD_CLEAR;
      FUNC_READ_CELL:  cmd_o.kind = CMD_READ;
      FUNC_ERROR_MARK: cmd_o.kind = CMD_ERROR;
      default:         cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

// ----- sv/tcw_cmd_fifo.sv -----
`timescale 1ns / 1ps

module tcw_cmd_fifo import tcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  cmd_t                entries_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FIFO_PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0]  count_q, count_d;

  assign full_o  = (32'(count_q) == FIFO_DEPTH);
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : FIFO_PW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : FIFO_PW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = FIFO_CW'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = FIFO_CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- sv/tcw_back.sv -----
`timescale 1ns / 1ps

module tcw_back import tcw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [ATTR_W-1:0]    text_attr_i,
  input  logic [ATTR_W-1:0]    error_attr_i,
  input  cmd_t                 head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output back_status_t         status_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CURSOR_W-1:0]  cursor_cell_o,
  output logic [CHAR_W-1:0]    read_char_o,
  output logic [ATTR_W-1:0]    read_attr_o
);

  back_state_e         state_q, state_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic [RW-1:0]       row_q, row_d;
  logic [CLW-1:0]      col_q, col_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [ATTR_W-1:0]   fill_q, fill_d;
  logic                reply_q, reply_d;
  logic                apply_q, apply_d;
  cmd_t                cmd_q, cmd_d;
  logic                out_valid_q, out_valid_d;
  logic [CURSOR_W-1:0] out_cursor_q, out_cursor_d;
  logic [CHAR_W-1:0]   out_char_q, out_char_d;
  logic [ATTR_W-1:0]   out_attr_q, out_attr_d;

  // Screen store
  logic [15:0]         mem [CELLS];
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [15:0]         mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [15:0]         rdata_q;

  logic                out_free;
  logic                finish;
  logic                last_row;
  logic                past_end;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) & ~empty_i & out_free;
  assign last_row = (32'(row_q) >= ROWS - 1);
  assign past_end = (32'(row_q) == ROWS);

  assign status_o.init_busy = (state_q == ST_FILL) & ~reply_q;

  assign out_valid_o   = out_valid_q;
  assign cursor_cell_o = out_cursor_q;
  assign read_char_o   = out_char_q;
  assign read_attr_o   = out_attr_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          unique case (head_i.kind)
            CMD_PUT, CMD_PUT_LF: state_d = past_end ? ST_SHIFT : ST_APPLY;
            CMD_LF:              state_d = last_row ? ST_SHIFT : ST_IDLE;
            CMD_CLEAR:           state_d = ST_FILL;
            CMD_READ:            state_d = ST_READ;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_SHIFT: begin
        if (32'(cnt_q) == CELLS - COLUMNS) state_d = ST_BLANK;
      end
      ST_BLANK: begin
        if (32'(cnt_q) == CELLS - 1) state_d = apply_q ? ST_APPLY : ST_IDLE;
      end
      ST_FILL: begin
        if (32'(cnt_q) == CELLS - 1) state_d = ST_IDLE;
      end
      ST_APPLY: state_d = ST_IDLE;
      ST_READ:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and store access
  always_comb begin
    pos_d      = pos_q;
    row_d      = row_q;
    col_d      = col_q;
    cnt_d      = cnt_q;
    fill_d     = fill_q;
    reply_d    = reply_q;
    apply_d    = apply_q;
    cmd_d      = cmd_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;
    finish     = 1'b0;
    out_char_d = '0;
    out_attr_d = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          cmd_d = head_i;
          unique case (head_i.kind)
            CMD_PUT, CMD_PUT_LF: begin
              // scroll first when past the end
              if (past_end) begin
                pos_d   = PW'(CELLS - COLUMNS);
                row_d   = RW'(ROWS - 1);
                col_d   = '0;
                cnt_d   = '0;
                apply_d = 1'b1;
              end
            end
            CMD_LF: begin
              col_d = '0;
              if (last_row) begin
                // move a row down, then scroll back up
                pos_d   = PW'(pos_q - PW'(col_q));
                cnt_d   = '0;
                apply_d = 1'b0;
              end else begin
                pos_d  = PW'(pos_q - PW'(col_q) + PW'(COLUMNS));
                row_d  = RW'(row_q + 1'b1);
                finish = 1'b1;
              end
            end
            CMD_BS: begin
              if (pos_q != '0) begin
                pos_d     = PW'(pos_q - 1'b1);
                mem_we    = 1'b1;
                mem_waddr = AW'(pos_q - 1'b1);
                mem_wdata = {text_attr_i, BLANK_CHAR};
                if (col_q == '0) begin
                  col_d = CLW'(COLUMNS - 1);
                  row_d = RW'(row_q - 1'b1);
                end else begin
                  col_d = CLW'(col_q - 1'b1);
                end
              end
              finish = 1'b1;
            end
            CMD_CLEAR: begin
              pos_d   = '0;
              row_d   = '0;
              col_d   = '0;
              cnt_d   = '0;
              fill_d  = text_attr_i;
              reply_d = 1'b1;
            end
            CMD_READ: begin
              mem_raddr = head_i.idx;
            end
            CMD_ERROR: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(CELLS - 1);
              mem_wdata = {error_attr_i, ERROR_CHAR};
              finish    = 1'b1;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      ST_SHIFT: begin
        // read one row below, write the previous read back one row up
        if (32'(cnt_q) < CELLS - COLUMNS) begin
          mem_raddr = AW'(32'(cnt_q) + COLUMNS);
          cnt_d     = AW'(cnt_q + 1'b1);
        end
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_q - 1'b1);
          mem_wdata = rdata_q;
        end
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = {text_attr_i, BLANK_CHAR};
        if (32'(cnt_q) == CELLS - 1) begin
          finish = ~apply_q;
        end else begin
          cnt_d = AW'(cnt_q + 1'b1);
        end
      end
      ST_APPLY: begin
        if (cmd_q.kind == CMD_PUT_LF) begin
          pos_d = PW'(pos_q - PW'(col_q) + PW'(COLUMNS));
          col_d = '0;
          row_d = RW'(row_q + 1'b1);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_q);
          mem_wdata = {text_attr_i, cmd_q.ch};
          pos_d     = PW'(pos_q + 1'b1);
          if (32'(col_q) == COLUMNS - 1) begin
            col_d = '0;
            row_d = RW'(row_q + 1'b1);
          end else begin
            col_d = CLW'(col_q + 1'b1);
          end
        end
        finish = 1'b1;
      end
      ST_READ: begin
        if (cmd_q.in_range) begin
          out_char_d = rdata_q[CHAR_W-1:0];
          out_attr_d = rdata_q[15:CHAR_W];
        end
        finish = 1'b1;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = {fill_q, BLANK_CHAR};
        if (32'(cnt_q) == CELLS - 1) begin
          finish  = reply_q;
          reply_d = 1'b0;
        end else begin
          cnt_d = AW'(cnt_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_d  = out_valid_q & out_stall_i;
    out_cursor_d = out_cursor_q;
    if (finish) begin
      out_valid_d  = 1'b1;
      out_cursor_d = CURSOR_W'(pos_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      pos_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      fill_q      <= TEXT_ATTR_RST;
      reply_q     <= 1'b0;
      apply_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      reply_q     <= reply_d;
      apply_q     <= apply_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (finish) begin
      out_char_q <= out_char_d;
      out_attr_q <= out_attr_d;
    end
    out_cursor_q <= out_cursor_d;
  end

  // Screen store ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

endmodule
